[rtl/core/brrqm_pkg.sv]
// Shared types and constants for the burst round-robin queue merge block.
// No dependencies; imported by every module of the block.
`default_nettype none

package brrqm_pkg;

  localparam int NUM_QUEUES_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int VALUE_W     = 31;
  localparam int QIDX_W      = 4;
  localparam int BLEN_W      = 7;
  localparam int QCNT_W      = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_PULL   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_COUNT = 2'd1;

  // counter table commands from the sequencer
  typedef struct packed {
    logic inc_fill;
    logic inc_rd;
  } ctr_cmd_t;

  // compare results for the selected queue
  typedef struct packed {
    logic not_full;
    logic has_data;
  } ctr_stat_t;

endpackage

`default_nettype wire

[rtl/core/brrqm_store.sv]
// Value storage for all queues: one port, written or read once per cycle.
// Depends on brrqm_pkg for the value width.
`default_nettype none

module brrqm_store
  import brrqm_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int AW = QW + PW
) (
  input  wire                 clk,
  input  wire                 we,
  input  wire                 re,
  input  wire  [AW-1:0]       addr,
  input  wire  [VALUE_W-1:0]  wdata,
  output logic [VALUE_W-1:0]  rdata
);

  localparam int DEPTH = NUM_QUEUES * (1 << PW);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/brrqm_ctrs.sv]
// Per-queue fill counts and read positions with the shared compare unit.
// Depends on brrqm_pkg for the command and status structs.
`default_nettype none

module brrqm_ctrs
  import brrqm_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int FW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire  [QW-1:0]    idx,
  input  ctr_cmd_t         cmd,
  output ctr_stat_t        stat,
  output logic [FW-1:0]    fill_pos,
  output logic [FW-1:0]    rd_pos
);

  logic [FW-1:0] fill_r [NUM_QUEUES];
  logic [FW-1:0] rd_r   [NUM_QUEUES];
  logic          idx_ok;

  assign idx_ok   = {1'b0, idx} < (QW+1)'(NUM_QUEUES);
  assign fill_pos = idx_ok ? fill_r[idx] : '0;
  assign rd_pos   = idx_ok ? rd_r[idx]   : '0;

  // read position never passes fill count, which never passes the depth
  assign stat.not_full = idx_ok && (int'(fill_pos) < QUEUE_DEPTH);
  assign stat.has_data = idx_ok && (rd_pos < fill_pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        fill_r[i] <= '0;
        rd_r[i]   <= '0;
      end
    end else if (idx_ok) begin
      if (cmd.inc_fill) begin
        fill_r[idx] <= fill_pos + 1'b1;
      end
      if (cmd.inc_rd) begin
        rd_r[idx] <= rd_pos + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/brrqm_seq.sv]
// Sequencer: append and pull transactions, round-robin scan, result register.
// Depends on brrqm_pkg; drives brrqm_ctrs and brrqm_store.
`default_nettype none

module brrqm_seq
  import brrqm_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int FW = $clog2(QUEUE_DEPTH + 1),
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int AW = QW + PW
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 in_op,
  input  wire  [QIDX_W-1:0]   in_queue_index,
  input  wire  [VALUE_W-1:0]  in_value,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [VALUE_W-1:0]  out_value_res,
  output logic [QIDX_W-1:0]   out_source_queue,
  output logic                out_done_res,
  output logic                out_overflow,
  input  wire  [BLEN_W-1:0]   burst_len,
  input  wire  [QCNT_W-1:0]   queue_count,
  output logic [QW-1:0]       ctr_idx,
  output ctr_cmd_t            ctr_cmd,
  input  ctr_stat_t           ctr_stat,
  input  wire  [FW-1:0]       fill_pos,
  input  wire  [FW-1:0]       rd_pos,
  output logic                mem_we,
  output logic                mem_re,
  output logic [AW-1:0]       mem_addr,
  output logic [VALUE_W-1:0]  mem_wdata,
  input  wire  [VALUE_W-1:0]  mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_PREP,
    S_SCAN,
    S_EMIT
  } state_t;

  localparam int CNT_SAT = (NUM_QUEUES > 31) ? 31 : NUM_QUEUES;

  state_t              state_r;
  logic [QIDX_W-1:0]   qi_r;
  logic [VALUE_W-1:0]  val_r;
  logic [QW-1:0]       cur_r;
  logic [BLEN_W-1:0]   bt_r;
  logic [QCNT_W:0]     k_r;
  logic                done_r;
  logic                overflow_r;
  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic [QIDX_W-1:0]   out_source_r;
  logic                out_done_r;
  logic                out_overflow_r;

  logic [QCNT_W-1:0]   cnt;
  logic [BLEN_W-1:0]   blen;
  logic [QW:0]         cur_inc;
  logic [QW-1:0]       cur_next;
  logic                qi_ok;
  logic                take;
  logic                is_append;

  assign cnt  = (queue_count > QCNT_W'(CNT_SAT)) ? QCNT_W'(CNT_SAT) : queue_count;
  assign blen = (burst_len == '0) ? BLEN_W'(1) : burst_len;

  assign cur_inc  = {1'b0, cur_r} + 1'b1;
  assign cur_next = (int'(cur_inc) >= int'(cnt)) ? '0 : cur_inc[QW-1:0];

  assign qi_ok     = int'(qi_r) < NUM_QUEUES;
  assign is_append = (state_r == S_APPEND);
  assign take      = (bt_r < blen) && ctr_stat.has_data;

  assign ctr_idx  = is_append ? QW'(qi_r) : cur_r;
  assign mem_we   = is_append && qi_ok && ctr_stat.not_full;
  assign mem_re   = (state_r == S_SCAN) && take;
  assign mem_addr = {ctr_idx, PW'(is_append ? fill_pos : rd_pos)};
  assign mem_wdata = val_r;

  assign ctr_cmd.inc_fill = mem_we;
  assign ctr_cmd.inc_rd   = mem_re;

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_value_res    = out_value_r;
  assign out_source_queue = out_source_r;
  assign out_done_res     = out_done_r;
  assign out_overflow     = out_overflow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      bt_r        <= '0;
      k_r         <= '0;
      done_r      <= 1'b0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_EMIT the result register is refilled below whenever it drains
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            qi_r    <= in_queue_index;
            val_r   <= in_value;
            state_r <= (in_op == OP_PULL) ? S_PREP : S_APPEND;
          end
        end
        S_APPEND: begin
          // out-of-range queue index is dropped silently
          if (qi_ok && !ctr_stat.not_full) begin
            overflow_r <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        S_PREP: begin
          k_r <= '0;
          if (cnt == '0) begin
            done_r  <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            done_r <= 1'b0;
            // count shrank below the current queue: fresh turn at queue 0
            if (int'(cur_r) >= int'(cnt)) begin
              cur_r <= '0;
              bt_r  <= '0;
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (take) begin
            bt_r    <= bt_r + 1'b1;
            done_r  <= 1'b0;
            state_r <= S_EMIT;
          end else begin
            cur_r <= cur_next;
            bt_r  <= '0;
            // count+1 misses: every queue checked, current one twice
            if (k_r == {1'b0, cnt}) begin
              done_r  <= 1'b1;
              state_r <= S_EMIT;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_value_r    <= done_r ? '0 : mem_rdata;
            out_source_r   <= done_r ? '0 : QIDX_W'(cur_r);
            out_done_r     <= done_r;
            out_overflow_r <= overflow_r;
            out_valid_r    <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_take_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && take) |=> (state_r == S_EMIT && !done_r))
    else $error("read from a queue did not lead to a value result");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_value_r == '0 && out_source_r == '0))
    else $error("done result carries a nonzero value or source");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid_r && !out_ready) |=> (state_r == S_EMIT))
    else $error("pending result overwritten while receiver stalls");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_r <= {1'b0, cnt}))
    else $error("scan ran past queue count plus one checks");
`endif

endmodule

`default_nettype wire

[rtl/core/burst_round_robin_queue_merge.sv]
// Burst round-robin queue merge: appends values to queues and pulls a merged
// stream. Top level; depends on brrqm_pkg, brrqm_store, brrqm_ctrs, brrqm_seq.
//
// Input channel (in_*): op 0 appends in_value to queue in_queue_index and
// gives no result; op 1 pulls the next merged value. Output channel (out_*):
// one result per pull with value, source queue, done and sticky overflow.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 burst
// length, 1 queue count); write only while the block is idle.
// Timing: in_ready is high only between transactions. An append passes
// through state S_APPEND. A pull passes through S_PREP, then s queue checks
// in S_SCAN by the shared compare unit, then S_EMIT, which writes the result
// register; s is 0 with a zero queue count, else 1 to the served count + 1
// (at most 17 with 16 queues); one check per cycle against one queue.
// The result sits in an output register; a stalled receiver holds the block
// only when a further pull's result is ready to be written there.
// Reset (rst_n low, synchronous) empties all queues, clears overflow and
// returns to queue 0; burst length and queue count return to 1. The value
// store has no reset and needs no clearing pass.
`default_nettype none

module burst_round_robin_queue_merge
  import brrqm_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    in_op,
  input  wire  [QIDX_W-1:0]      in_queue_index,
  input  wire  [VALUE_W-1:0]     in_value,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [VALUE_W-1:0]     out_value_res,
  output logic [QIDX_W-1:0]      out_source_queue,
  output logic                   out_done_res,
  output logic                   out_overflow,
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int AW = QW + PW;

  logic [BLEN_W-1:0]  burst_len_r;
  logic [QCNT_W-1:0]  queue_count_r;

  logic [QW-1:0]      ctr_idx;
  ctr_cmd_t           ctr_cmd;
  ctr_stat_t          ctr_stat;
  logic [FW-1:0]      fill_pos;
  logic [FW-1:0]      rd_pos;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_addr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [VALUE_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_len_r   <= BLEN_W'(1);
      queue_count_r <= QCNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BURST_LEN:   burst_len_r   <= cfg_wdata[BLEN_W-1:0];
        CFG_QUEUE_COUNT: queue_count_r <= cfg_wdata[QCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  brrqm_seq #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_queue_index   (in_queue_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value_res    (out_value_res),
    .out_source_queue (out_source_queue),
    .out_done_res     (out_done_res),
    .out_overflow     (out_overflow),
    .burst_len        (burst_len_r),
    .queue_count      (queue_count_r),
    .ctr_idx          (ctr_idx),
    .ctr_cmd          (ctr_cmd),
    .ctr_stat         (ctr_stat),
    .fill_pos         (fill_pos),
    .rd_pos           (rd_pos),
    .mem_we           (mem_we),
    .mem_re           (mem_re),
    .mem_addr         (mem_addr),
    .mem_wdata        (mem_wdata),
    .mem_rdata        (mem_rdata)
  );

  brrqm_ctrs #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrs (
    .clk      (clk),
    .rst_n    (rst_n),
    .idx      (ctr_idx),
    .cmd      (ctr_cmd),
    .stat     (ctr_stat),
    .fill_pos (fill_pos),
    .rd_pos   (rd_pos)
  );

  brrqm_store #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
